// ===== hdl/catmull_rom_keyframe_eval_defines.svh =====
// assertion macros shared by the checker
`ifndef CATMULL_ROM_KEYFRAME_EVAL_DEFINES_SVH
`define CATMULL_ROM_KEYFRAME_EVAL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CKF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyframe evaluator check failed");

// next-cycle implication, disabled in reset
`define CKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe evaluator check failed");

`endif

// ===== hdl/ckf_pkg.sv =====
package ckf_pkg;

  localparam int unsigned MaxKeysDef = 64;
  localparam int unsigned KeyCountW  = 7;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FracW      = 16;
  localparam int unsigned WeightW    = 32;
  localparam int unsigned ProdW      = 64;
  localparam int unsigned AccW       = 66;
  localparam int unsigned PolyW      = 56;
  localparam int unsigned BitCntW    = 5;

  // action codes
  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_LAST_RD,
    OP_LAST_CHK,
    OP_MOD,
    OP_SCAN,
    OP_DIV,
    OP_POW2,
    OP_POW3,
    OP_WGT,
    OP_BL_RD,
    OP_BL_MUL,
    OP_LD_ZERO,
    OP_LD_POINT,
    OP_LD_BLEND
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLASS,
    ST_LAST_RD,
    ST_LAST_CHK,
    ST_MOD,
    ST_SCAN,
    ST_DIV,
    ST_POW2,
    ST_POW3,
    ST_WGT,
    ST_BL_RD,
    ST_BL_MUL,
    ST_BL_END,
    ST_PT_RD,
    ST_PT_OUT,
    ST_RES_ZERO,
    ST_RES_BLEND
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic last_zero;
    logic mod_done;
    logic div_done;
    logic scan_hit;
    logic scan_miss;
    logic hit_first;
    logic ax_last;
    logic k_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/ckf_in_if.sv =====
interface ckf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  key_index;
  logic [31:0] key_time;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] query_time;

  modport source (
    output valid, action, key_index, key_time, pos_x, pos_y, pos_z, query_time,
    input  ready
  );
  modport sink (
    input  valid, action, key_index, key_time, pos_x, pos_y, pos_z, query_time,
    output ready
  );
endinterface

// ===== hdl/ckf_out_if.sv =====
interface ckf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        status;

  modport source (
    output valid, out_x, out_y, out_z, status,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, status,
    output ready
  );
endinterface

// ===== hdl/ckf_ram.sv =====
module ckf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/ckf_ctrl.sv =====
module ckf_ctrl import ckf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_action_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_action_i == ActQuery)) state_d = ST_CLASS;
      end
      ST_CLASS: begin
        if (sts_i.n_zero)      state_d = ST_RES_ZERO;
        else if (sts_i.n_one)  state_d = ST_PT_RD;
        else                   state_d = ST_LAST_RD;
      end
      ST_LAST_RD:  state_d = ST_LAST_CHK;
      ST_LAST_CHK: state_d = sts_i.last_zero ? ST_RES_ZERO : ST_MOD;
      ST_MOD: begin
        if (sts_i.mod_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_hit)       state_d = sts_i.hit_first ? ST_PT_RD : ST_DIV;
        else if (sts_i.scan_miss) state_d = ST_PT_RD;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_POW2;
      end
      ST_POW2:  state_d = ST_POW3;
      ST_POW3:  state_d = ST_WGT;
      ST_WGT:   state_d = ST_BL_RD;
      ST_BL_RD: state_d = ST_BL_MUL;
      ST_BL_MUL: begin
        if (sts_i.ax_last) state_d = sts_i.k_last ? ST_BL_END : ST_BL_RD;
      end
      ST_BL_END: state_d = ST_RES_BLEND;
      ST_PT_RD:  state_d = ST_PT_OUT;
      ST_PT_OUT, ST_RES_ZERO, ST_RES_BLEND: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = (in_action_i == ActQuery) ? OP_START : OP_LOAD;
      end
      ST_LAST_RD:   cmd_o.op = OP_LAST_RD;
      ST_LAST_CHK:  cmd_o.op = OP_LAST_CHK;
      ST_MOD:       cmd_o.op = OP_MOD;
      ST_SCAN:      cmd_o.op = OP_SCAN;
      ST_DIV:       cmd_o.op = OP_DIV;
      ST_POW2:      cmd_o.op = OP_POW2;
      ST_POW3:      cmd_o.op = OP_POW3;
      ST_WGT:       cmd_o.op = OP_WGT;
      ST_BL_RD:     cmd_o.op = OP_BL_RD;
      ST_BL_MUL:    cmd_o.op = OP_BL_MUL;
      ST_PT_OUT:    cmd_o.op = sts_i.out_free ? OP_LD_POINT : OP_NONE;
      ST_RES_ZERO:  cmd_o.op = sts_i.out_free ? OP_LD_ZERO : OP_NONE;
      ST_RES_BLEND: cmd_o.op = sts_i.out_free ? OP_LD_BLEND : OP_NONE;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/ckf_dp.sv =====
module ckf_dp import ckf_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic                 cfg_we_i,
  input  logic [KeyCountW-1:0] cfg_wdata_i,
  input  logic [IndexW-1:0]    key_index_i,
  input  logic [DataW-1:0]     key_time_i,
  input  logic [DataW-1:0]     pos_x_i,
  input  logic [DataW-1:0]     pos_y_i,
  input  logic [DataW-1:0]     pos_z_i,
  input  logic [DataW-1:0]     query_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataW-1:0]     out_x_o,
  output logic [DataW-1:0]     out_y_o,
  output logic [DataW-1:0]     out_z_o,
  output logic                 status_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned PtW = 3 * DataW;
  localparam logic signed [PolyW-1:0] WOne     = PolyW'(1) << 50;
  localparam logic signed [PolyW-1:0] WRound   = PolyW'(1) << 19;
  localparam logic signed [AccW-1:0]  AccRound = AccW'(1) << 29;

  // configuration and query registers
  logic [KeyCountW-1:0] key_count_q;
  logic [CW-1:0]        n_q, n_eff;
  logic [DataW-1:0]     qt_q, last_q, rem_q, prev_q, dr_q, den_q;
  logic [BitCntW-1:0]   cnt_q;
  logic [CW-1:0]        idx_q;
  logic                 chk_q;
  logic [AW-1:0]        i_q, pt_addr_q, ix;
  logic [FracW-1:0]     u_q;
  logic [2*FracW-1:0]   u2_q;
  logic [3*FracW-1:0]   u3_q;
  logic signed [WeightW-1:0] w_q [4];
  logic [1:0]           k_q, ax_q, pax_q;
  logic signed [ProdW-1:0] prod_q;
  logic                 pv_q;
  logic signed [AccW-1:0] acc_q [3];
  logic                 out_valid_q;

  // memories
  logic             t_we;
  logic [AW-1:0]    waddr, t_raddr, p_raddr;
  logic [DataW-1:0] t_rdata;
  logic [PtW-1:0]   p_rdata;

  assign t_we  = (cmd_i.op == OP_LOAD) && (32'(key_index_i) < MAX_KEYS);
  assign waddr = AW'(key_index_i);

  always_comb begin
    t_raddr = AW'(idx_q);
    if (cmd_i.op == OP_LAST_RD) t_raddr = AW'(n_q - CW'(1));
  end

  always_comb begin
    p_raddr = pt_addr_q;
    if (cmd_i.op == OP_BL_RD || cmd_i.op == OP_BL_MUL) p_raddr = ix;
  end

  ckf_ram #(.Width(DataW), .Depth(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (waddr),
    .wdata_i (key_time_i),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ckf_ram #(.Width(PtW), .Depth(MAX_KEYS)) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (waddr),
    .wdata_i ({pos_x_i, pos_y_i, pos_z_i}),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // effective key count
  always_comb begin
    if (32'(key_count_q) > MAX_KEYS) n_eff = CW'(MAX_KEYS);
    else                             n_eff = CW'(key_count_q);
  end

  // control point index for the current blend step
  logic seg_end;
  always_comb begin
    seg_end = (32'(i_q) < 32'd2) || (CW'(i_q) == (n_q - CW'(1)));
    unique case (k_q)
      2'd0:    ix = seg_end ? (i_q - AW'(1)) : (i_q - AW'(2));
      2'd1:    ix = i_q - AW'(1);
      2'd2:    ix = i_q;
      default: ix = seg_end ? i_q : (i_q + AW'(1));
    endcase
  end

  // restoring steps for the modulo and the division
  logic [DataW:0] mod_t, div_t;
  logic           mod_ge, div_ge;
  assign mod_t  = {rem_q, qt_q[DataW-1]};
  assign mod_ge = mod_t >= {1'b0, last_q};
  assign div_t  = {dr_q, 1'b0};
  assign div_ge = div_t >= {1'b0, den_q};

  // scan compare
  logic hit;
  assign hit = chk_q && (t_rdata > rem_q);

  // basis weights at scale 2^50, rounded to q2.30
  logic signed [PolyW-1:0] su, su2, su3, a0, a1, a2, a3;
  always_comb begin
    su  = $signed(PolyW'(u_q));
    su2 = $signed(PolyW'(u2_q));
    su3 = $signed(PolyW'(u3_q));
    a0  = -(su <<< 32) + (su2 <<< 17) - su3;
    a1  = WOne - 11 * (su2 <<< 16) + 7 * su3;
    a2  = (su <<< 32) + 10 * (su2 <<< 16) - 7 * su3;
    a3  = -(su2 <<< 16) + su3;
  end

  // multiplier operand
  logic signed [DataW-1:0] axis;
  always_comb begin
    unique case (ax_q)
      2'd0:    axis = $signed(p_rdata[3*DataW-1:2*DataW]);
      2'd1:    axis = $signed(p_rdata[2*DataW-1:DataW]);
      default: axis = $signed(p_rdata[DataW-1:0]);
    endcase
  end

  // rounding and saturation of the sums
  logic [DataW-1:0] blend_res [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [AccW-1:0] sv;
      sv = (acc_q[a] + AccRound) >>> 30;
      if (sv[AccW-1:DataW-1] == '0 || sv[AccW-1:DataW-1] == '1) begin
        blend_res[a] = sv[DataW-1:0];
      end else begin
        blend_res[a] = sv[AccW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
      chk_q       <= 1'b0;
    end else begin
      if (cfg_we_i) key_count_q <= cfg_wdata_i;
      pv_q <= (cmd_i.op == OP_BL_MUL);
      if (cmd_i.op == OP_LD_ZERO || cmd_i.op == OP_LD_POINT || cmd_i.op == OP_LD_BLEND) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_MOD) chk_q <= 1'b0;
      else if (cmd_i.op == OP_SCAN) chk_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (pv_q) acc_q[pax_q] <= acc_q[pax_q] + AccW'(prod_q);
    unique case (cmd_i.op)
      OP_START: begin
        qt_q      <= query_time_i;
        n_q       <= n_eff;
        pt_addr_q <= '0;
      end
      OP_LAST_CHK: begin
        last_q <= t_rdata;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      OP_MOD: begin
        rem_q <= mod_ge ? DataW'(mod_t - {1'b0, last_q}) : mod_t[DataW-1:0];
        qt_q  <= {qt_q[DataW-2:0], 1'b0};
        cnt_q <= cnt_q + BitCntW'(1);
        idx_q <= '0;
      end
      OP_SCAN: begin
        if (hit) begin
          i_q   <= AW'(idx_q - CW'(1));
          dr_q  <= rem_q - prev_q;
          den_q <= t_rdata - prev_q;
          cnt_q <= '0;
        end else if (chk_q && idx_q == n_q) begin
          pt_addr_q <= AW'(n_q - CW'(1));
        end else begin
          prev_q <= t_rdata;
          idx_q  <= idx_q + CW'(1);
        end
      end
      OP_DIV: begin
        dr_q  <= div_ge ? DataW'(div_t - {1'b0, den_q}) : div_t[DataW-1:0];
        u_q   <= {u_q[FracW-2:0], div_ge};
        cnt_q <= cnt_q + BitCntW'(1);
      end
      OP_POW2: u2_q <= u_q * u_q;
      OP_POW3: u3_q <= u2_q * u_q;
      OP_WGT: begin
        w_q[0] <= WeightW'((a0 + WRound) >>> 20);
        w_q[1] <= WeightW'((a1 + WRound) >>> 20);
        w_q[2] <= WeightW'((a2 + WRound) >>> 20);
        w_q[3] <= WeightW'((a3 + WRound) >>> 20);
        k_q    <= '0;
        ax_q   <= '0;
        for (int a = 0; a < 3; a++) acc_q[a] <= '0;
      end
      OP_BL_MUL: begin
        prod_q <= w_q[k_q] * axis;
        pax_q  <= ax_q;
        if (ax_q == 2'd2) begin
          ax_q <= '0;
          k_q  <= k_q + 2'd1;
        end else begin
          ax_q <= ax_q + 2'd1;
        end
      end
      OP_LD_ZERO: begin
        out_x_o  <= '0;
        out_y_o  <= '0;
        out_z_o  <= '0;
        status_o <= 1'b1;
      end
      OP_LD_POINT: begin
        out_x_o  <= p_rdata[3*DataW-1:2*DataW];
        out_y_o  <= p_rdata[2*DataW-1:DataW];
        out_z_o  <= p_rdata[DataW-1:0];
        status_o <= 1'b0;
      end
      OP_LD_BLEND: begin
        out_x_o  <= blend_res[0];
        out_y_o  <= blend_res[1];
        out_z_o  <= blend_res[2];
        status_o <= 1'b0;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    sts_o.n_zero    = (n_q == '0);
    sts_o.n_one     = (n_q == CW'(1));
    sts_o.last_zero = (t_rdata == '0);
    sts_o.mod_done  = (cnt_q == BitCntW'(DataW - 1));
    sts_o.div_done  = (cnt_q == BitCntW'(FracW - 1));
    sts_o.scan_hit  = hit;
    sts_o.scan_miss = !hit && chk_q && (idx_q == n_q);
    sts_o.hit_first = (idx_q == CW'(1));
    sts_o.ax_last   = (ax_q == 2'd2);
    sts_o.k_last    = (k_q == 2'd3);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/catmull_rom_keyframe_eval.sv =====
// Catmull-Rom keyframe evaluator, tension 0.25.
// in_i carries items: action 0 writes one keyframe (time and x/y/z) into
// entry key_index and gives no result; action 1 evaluates the curve at
// query_time and gives one result on out_o (x/y/z in signed q16.16, status).
// cfg_we_i/cfg_wdata_i write key_count; the user must write it only while the
// block is idle, which the block itself does not enforce. A query passes a
// bit-serial modulo of query_time by the last key time, a linear key scan at
// one table read per cycle, a bit-serial division for the 16-bit local
// parameter, and twelve multiply steps on one shared 32x32 multiplier. An
// empty table, a single key or a zero last key time skip the modulo, scan and
// division; a time before the first key skips the division and multiply steps.
// One item is worked on at a time; the next is taken once the result sits in
// the output register, which holds it while the receiver stalls.
// Reset clears key_count and the control state; the key tables are not
// cleared and must be loaded before they are used.
module catmull_rom_keyframe_eval import ckf_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ckf_in_if.sink               in_i,
  ckf_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [KeyCountW-1:0] cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  ckf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // tables and arithmetic
  ckf_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_index_i  (in_i.key_index),
    .key_time_i   (in_i.key_time),
    .pos_x_i      (in_i.pos_x),
    .pos_y_i      (in_i.pos_y),
    .pos_z_i      (in_i.pos_z),
    .query_time_i (in_i.query_time),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_z_o      (out_o.out_z),
    .status_o     (out_o.status)
  );

endmodule

// ===== hdl/ckf_checker.sv =====
`include "catmull_rom_keyframe_eval_defines.svh"

module ckf_checker import ckf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i,
  input logic [31:0] out_y_i,
  input logic [31:0] out_z_i,
  input logic        out_status_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a result waits until taken
  `CKF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // a waiting result keeps its value
  `CKF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i) && $stable(out_status_i))
  // a load item makes no result
  `CKF_ASSERT_NEXT(a_load_silent, clk_i, rst_ni, in_acc && (in_action_i == ActLoad) && !out_valid_i, !out_valid_i)
  // a query item blocks the input while it is worked on
  `CKF_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_acc && (in_action_i == ActQuery), !in_ready_i)

endmodule

bind catmull_rom_keyframe_eval ckf_checker u_ckf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_action_i  (in_i.action),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_x_i      (out_o.out_x),
  .out_y_i      (out_o.out_y),
  .out_z_i      (out_o.out_z),
  .out_status_i (out_o.status)
);
